/* rtl/f2f_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2f_pkg
// Shared types and constants of the F2F stripe bit decoder: phase codes,
// register indexes, field widths and the packed result record.
// ----------------------------------------------------------------------------
package f2f_pkg;

	// Field widths
	localparam int SAMPLE_W = 10;
	localparam int TIMER_W  = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int IN_W     = 32;	// sample + timer, filled up to whole bytes
	localparam int OUT_W    = 40;	// result record, filled up to whole bytes

	// Phase codes as reported on the result
	typedef enum logic [1:0] {
		PH_PREAMBLE = 2'd0,
		PH_MEASURE  = 2'd1,
		PH_DATA     = 2'd2,
		PH_DONE     = 2'd3
	} phase_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MID      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 3'd4;

	// Register reset values
	localparam logic [CFG_W-1:0]    PREAMBLE_RST = 16'd8;
	localparam logic [CFG_W-1:0]    SYNC_RST     = 16'd16;
	localparam logic [SAMPLE_W-1:0] LOW_RST      = 10'h0ff;
	localparam logic [SAMPLE_W-1:0] MID_RST      = 10'h200;
	localparam logic [SAMPLE_W-1:0] HIGH_RST     = 10'h300;

	localparam logic [TIMER_W-1:0] COUNT_MAX = 16'hffff;

	// Result record, last field in the lowest bits
	typedef struct packed {
		logic [6:0]         pad;
		logic               track_full;
		logic [7:0]         byte_value;
		logic               byte_valid;
		logic               bit_value;
		logic               bit_valid;
		logic [TIMER_W-1:0] timer_load_value;
		logic               timer_load_valid;
		logic               timer_start;
		phase_t             phase;
		logic               level;
	} result_t;

endpackage

/* rtl/f2f_stripe_bit_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2f_stripe_bit_decoder
// Slices head samples with hysteresis, locks onto the preamble, averages the
// bit period and decodes F2F data bits into bytes until the track is full.
// ----------------------------------------------------------------------------
// One sample enters per clock cycle while the result side takes results. A
// transfer is captured in the input register, then the slicer, phase decode
// and bit packer work on it against the running state and write the result
// register, which offers it. The decoder state loop holds no further
// register, which is what sets the rate of one sample per cycle; a result
// that waits holds the input register, which stalls the input side once full.
// After TRACK_BYTES bytes the block reports phase done and track_full on every
// further sample until reset. Configuration writes belong to idle periods.
// ----------------------------------------------------------------------------
module f2f_stripe_bit_decoder #(
	parameter int TRACK_BYTES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [f2f_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [f2f_pkg::CFG_W-1:0]         cfg_data,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [f2f_pkg::IN_W-1:0]          s_tdata,	// sample[9:0], timer_value[25:10]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [f2f_pkg::OUT_W-1:0]         m_tdata	// level, phase[1:0], timer_start,
	                                                    // timer_load_valid,
	                                                    // timer_load_value[15:0],
	                                                    // bit_valid, bit_value, byte_valid,
	                                                    // byte_value[7:0], track_full
);
	import f2f_pkg::*;

	localparam int BYTE_CNT_W = $clog2(TRACK_BYTES + 1);
	localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(TRACK_BYTES - 1);

	// configuration registers
	logic [CFG_W-1:0]    preamble_q, sync_q;
	logic [SAMPLE_W-1:0] low_q, mid_q, high_q;

	// input stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [TIMER_W-1:0]  timer_s1;

	// decoder state
	logic                  last_level_q;
	logic [TIMER_W-1:0]    count_q;
	logic [TIMER_W-1:0]    period_q;
	logic [7:0]            shift_q;
	logic [2:0]            bits_q;
	logic [BYTE_CNT_W-1:0] bytes_q;
	logic                  finished_q;

	// result stage
	logic    valid_s2;
	result_t res_s2;

	logic    advance;
	logic    step;

	// next-state and result logic
	logic                  data_ph;
	logic                  lvl;
	logic                  changed;
	logic [TIMER_W-1:0]    count_inc;
	logic [TIMER_W-1:0]    count_d;
	logic [TIMER_W-1:0]    period_d;
	logic [7:0]            shift_d;
	logic [7:0]            shift_new;
	logic [2:0]            bits_d;
	logic [BYTE_CNT_W-1:0] bytes_d;
	logic                  finished_d;
	result_t               res_d;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RST;
			sync_q     <= SYNC_RST;
			low_q      <= LOW_RST;
			mid_q      <= MID_RST;
			high_q     <= HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PREAMBLE: preamble_q <= cfg_data;
				REG_SYNC:     sync_q     <= cfg_data;
				REG_LOW:      low_q      <= cfg_data[SAMPLE_W-1:0];
				REG_MID:      mid_q      <= cfg_data[SAMPLE_W-1:0];
				REG_HIGH:     high_q     <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
			timer_s1  <= s_tdata[SAMPLE_W +: TIMER_W];
		end
	end

	// slice, decode phase and pack bits
	always_comb begin
		data_ph    = count_q > sync_q;
		count_inc  = (count_q == COUNT_MAX) ? count_q : count_q + TIMER_W'(1);
		count_d    = count_q;
		period_d   = period_q;
		shift_d    = shift_q;
		bits_d     = bits_q;
		bytes_d    = bytes_q;
		finished_d = finished_q;
		res_d      = '0;
		shift_new  = {shift_q[6:0], 1'b0};

		// hysteresis slicer, forced outside the bands once in data
		lvl = last_level_q;
		if (sample_s1 < mid_q) begin
			if (sample_s1 > low_q || data_ph) begin
				lvl = 1'b1;
			end
		end else begin
			if (sample_s1 < high_q || data_ph) begin
				lvl = 1'b0;
			end
		end
		changed = lvl != last_level_q;

		res_d.level = lvl;
		res_d.phase = PH_PREAMBLE;

		if (finished_q) begin
			// track complete: hold everything
			res_d.level      = last_level_q;
			res_d.phase      = PH_DONE;
			res_d.track_full = 1'b1;
		end else if (count_q < preamble_q) begin
			if (changed) begin
				count_d = count_inc;
			end
		end else if (count_q == preamble_q) begin
			res_d.timer_start = 1'b1;
			count_d           = count_inc;
		end else if (count_q < sync_q) begin
			res_d.phase = PH_MEASURE;
			if (changed) begin
				count_d = count_inc;
				if (period_q == '0) begin
					period_d = timer_s1;
				end else begin
					period_d = (timer_s1 >> 1) + (period_q >> 1);
				end
				res_d.timer_load_valid = 1'b1;
			end
		end else if (count_q == sync_q) begin
			res_d.phase = PH_MEASURE;
			if (changed) begin
				// first data sample lands at 1.125 periods
				res_d.timer_load_valid = 1'b1;
				res_d.timer_load_value = COUNT_MAX - period_q - (period_q >> 3);
				count_d                = count_inc;
			end
		end else begin
			res_d.phase     = PH_DATA;
			res_d.bit_valid = 1'b1;
			res_d.bit_value = !changed;
			shift_new       = {shift_q[6:0], !changed};
			bits_d          = bits_q + 3'd1;
			shift_d         = shift_new;
			if (bits_q == 3'd7) begin
				res_d.byte_valid = 1'b1;
				res_d.byte_value = shift_new;
				shift_d          = '0;
				bytes_d          = bytes_q + BYTE_CNT_W'(1);
				if (bytes_q == LAST_BYTE) begin
					finished_d       = 1'b1;
					res_d.track_full = 1'b1;
				end
			end
			res_d.timer_load_valid = 1'b1;
			res_d.timer_load_value = ~period_q;
		end
	end

	// advance decoder state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			count_q      <= '0;
			period_q     <= '0;
			shift_q      <= '0;
			bits_q       <= '0;
			bytes_q      <= '0;
			finished_q   <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (step && !finished_q) begin
				last_level_q <= lvl;
				count_q      <= count_d;
				period_q     <= period_d;
				shift_q      <= shift_d;
				bits_q       <= bits_d;
				bytes_q      <= bytes_d;
				finished_q   <= finished_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_d;
		end
	end

	// checks
	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag cleared without reset");

	a_byte_has_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.byte_valid) |-> (res_s2.bit_valid && res_s2.phase == PH_DATA))
		else $error("byte reported without a data bit");

	a_start_in_preamble: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.timer_start) |-> (res_s2.phase == PH_PREAMBLE
			&& !res_s2.timer_load_valid))
		else $error("timer start outside preamble");

	a_byte_clears_packer: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !finished_q && res_d.byte_valid) |=> (bits_q == 3'd0 && shift_q == 8'd0))
		else $error("packer not cleared after byte");

	a_full_means_done: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_d.track_full) |=> finished_q)
		else $error("track full reported but decoder still running");

endmodule

/* tb/sv/f2f_stripe_bit_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2f_stripe_bit_decoder_test
// Self-checking bench for the F2F stripe bit decoder. A short table of head
// samples after reset checks slicing at the band edges. It is followed by
// randomised runs that walk one track through its life: a long preamble
// under many threshold settings, the timer start, period averaging, the sync
// reload, data bits packed into bytes, and the track-full state. Every
// record is checked field by field against a local decoder model, or against a
// typed-in record on the marked table rows. Both stream sides idle at random,
// and the result side holds off once for a long stretch so that the decoder backs up.
// ----------------------------------------------------------------------------
module f2f_stripe_bit_decoder_test;
	import f2f_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;	// index with no register behind it
	localparam int HOLD_LEN    = 90;
	localparam int TRACK_BYTES = 16;

	// directed rows: the level is typed in where the row is marked
	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		logic [TIMER_W-1:0]  tv;
		logic                typed;
		logic                lvl;
	} dir_row_t;

	// reset thresholds: low 255, mid 512, high 768, level starts at zero
	localparam dir_row_t DIRECTED [13] = '{
		'{10'd0,    16'h0000, 1'b1, 1'b0},	// bottom of range, outside both bands
		'{10'd1023, 16'hffff, 1'b1, 1'b0},	// top of range, outside both bands
		'{10'd300,  16'h0000, 1'b1, 1'b1},	// one-side band
		'{10'd600,  16'hffff, 1'b1, 1'b0},	// zero-side band
		'{10'd256,  16'h0000, 1'b1, 1'b1},	// just above low
		'{10'd255,  16'hffff, 1'b1, 1'b1},	// at low, level held
		'{10'd511,  16'h0000, 1'b1, 1'b1},	// just below mid
		'{10'd512,  16'hffff, 1'b1, 1'b0},	// at mid
		'{10'd767,  16'h0000, 1'b1, 1'b0},	// just below high
		'{10'd768,  16'hffff, 1'b1, 1'b0},	// at high, level held
		'{10'd1,    16'h5555, 1'b0, 1'b0},
		'{10'd1022, 16'haaaa, 1'b0, 1'b0},
		'{10'd400,  16'h1234, 1'b0, 1'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;	// sample[9:0], timer_value[25:10], zero fill
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;	// level, phase[1:0], timer_start, timer_load_valid,
	                              	// timer_load_value[15:0], bit_valid, bit_value,
	                              	// byte_valid, byte_value[7:0], track_full, zero fill

	// local copy of the decoder registers and state
	logic [CFG_W-1:0]    preamble_len;
	logic [CFG_W-1:0]    sync_len;
	logic [SAMPLE_W-1:0] low_thr;
	logic [SAMPLE_W-1:0] mid_thr;
	logic [SAMPLE_W-1:0] high_thr;
	logic                level_q;
	logic [TIMER_W-1:0]  transitions_seen;
	logic [TIMER_W-1:0]  period_avg;
	logic [7:0]          byte_shift;
	int                  bits_packed;
	int                  byte_count;
	logic                track_done;

	result_t due_records[$];
	result_t got_rec;
	result_t want_rec;

	int  mismatches      = 0;
	int  records_checked = 0;
	int  samples_sent    = 0;
	int  start_count     = 0;
	bit  quiet           = 1'b0;
	bit  hold_req        = 1'b0;

	f2f_stripe_bit_decoder #(
		.TRACK_BYTES(TRACK_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop for a hung run
	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

	// decoder model: slice, advance the phase, pack bits
	function automatic result_t decode_sample(input logic [SAMPLE_W-1:0] v,
	                                          input logic [TIMER_W-1:0] tv);
		result_t r;
		logic    lvl;
		logic    changed;
		logic    in_data;
		r = '0;
		in_data = transitions_seen > sync_len;
		if (track_done) begin
			r.level = level_q;
			r.phase = PH_DONE;
			r.track_full = 1'b1;
			return r;
		end
		lvl = level_q;
		if (v < mid_thr) begin
			if (v > low_thr || in_data)
				lvl = 1'b1;
		end else begin
			if (v < high_thr || in_data)
				lvl = 1'b0;
		end
		changed = lvl != level_q;
		r.phase = PH_PREAMBLE;
		if (transitions_seen < preamble_len) begin
			if (changed && transitions_seen != COUNT_MAX)
				transitions_seen++;
		end else if (transitions_seen == preamble_len) begin
			r.timer_start = 1'b1;
			if (transitions_seen != COUNT_MAX)
				transitions_seen++;
		end else if (transitions_seen < sync_len) begin
			r.phase = PH_MEASURE;
			if (changed) begin
				if (transitions_seen != COUNT_MAX)
					transitions_seen++;
				if (period_avg == '0)
					period_avg = tv;
				else
					period_avg = (tv >> 1) + (period_avg >> 1);
				r.timer_load_valid = 1'b1;
				r.timer_load_value = '0;
			end
		end else if (transitions_seen == sync_len) begin
			r.phase = PH_MEASURE;
			if (changed) begin
				// first data sample lands at 1.125 periods
				r.timer_load_valid = 1'b1;
				r.timer_load_value = 16'hffff - period_avg - (period_avg >> 3);
				if (transitions_seen != COUNT_MAX)
					transitions_seen++;
			end
		end else begin
			r.phase = PH_DATA;
			r.bit_valid = 1'b1;
			r.bit_value = !changed;
			byte_shift = {byte_shift[6:0], r.bit_value};
			bits_packed++;
			if (bits_packed >= 8) begin
				r.byte_valid = 1'b1;
				r.byte_value = byte_shift;
				bits_packed = 0;
				byte_shift = '0;
				byte_count++;
				if (byte_count >= TRACK_BYTES) begin
					track_done = 1'b1;
					r.track_full = 1'b1;
				end
			end
			r.timer_load_valid = 1'b1;
			r.timer_load_value = 16'hffff - period_avg;
		end
		level_q = lvl;
		r.level = lvl;
		return r;
	endfunction

	// mostly samples close to a threshold, some extremes and some anywhere
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int t;
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2: return SAMPLE_W'($urandom_range(0, 1023));
			3:       return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
			default: begin
				case ($urandom_range(0, 2))
					0:       t = low_thr;
					1:       t = mid_thr;
					default: t = high_thr;
				endcase
				t = t + $urandom_range(0, 2) - 1;
				if (t < 0)
					t = 0;
				if (t > 1023)
					t = 1023;
				return SAMPLE_W'(t);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		mismatches++;
		$display("MISMATCH %s: got %0d, want %0d (record %0d)",
		         what, got_v, want_v, records_checked);
	endtask

	task automatic compare_record(input result_t got, input result_t want);
		if (got.level !== want.level)
			report_mismatch("level", got.level, want.level);
		if (got.phase !== want.phase)
			report_mismatch("phase", int'(got.phase), int'(want.phase));
		if (got.timer_start !== want.timer_start)
			report_mismatch("timer_start", got.timer_start, want.timer_start);
		if (got.timer_load_valid !== want.timer_load_valid)
			report_mismatch("timer_load_valid", got.timer_load_valid, want.timer_load_valid);
		if (got.timer_load_value !== want.timer_load_value)
			report_mismatch("timer_load_value", got.timer_load_value, want.timer_load_value);
		if (got.bit_valid !== want.bit_valid)
			report_mismatch("bit_valid", got.bit_valid, want.bit_valid);
		if (got.bit_value !== want.bit_value)
			report_mismatch("bit_value", got.bit_value, want.bit_value);
		if (got.byte_valid !== want.byte_valid)
			report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
		if (got.byte_value !== want.byte_value)
			report_mismatch("byte_value", got.byte_value, want.byte_value);
		if (got.track_full !== want.track_full)
			report_mismatch("track_full", got.track_full, want.track_full);
	endtask

	// check each record transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_rec = result_t'(m_tdata);
			if (due_records.size() == 0) begin
				report_mismatch("record with nothing due", 1, 0);
			end else begin
				want_rec = due_records.pop_front();
				compare_record(got_rec, want_rec);
				records_checked++;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one sample, wait for its transfer and predict its record
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIMER_W-1:0] tv,
	                           input bit use_typed = 1'b0, input result_t typed_rec = '0);
		result_t pred;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, tv, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = decode_sample(smp, tv);
		if (pred.timer_start)
			start_count = transitions_seen - 1;
		due_records.push_back(use_typed ? typed_rec : pred);
		samples_sent++;
		@(negedge clk);
	endtask

	// drop valid and wait until every record has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_records.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_PREAMBLE: preamble_len = data;
			REG_SYNC:     sync_len = data;
			REG_LOW:      low_thr = data[SAMPLE_W-1:0];
			REG_MID:      mid_thr = data[SAMPLE_W-1:0];
			REG_HIGH:     high_thr = data[SAMPLE_W-1:0];
			default:      ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// thresholds with random junk in the unused upper bits
	task automatic load_thresholds(input int lo, input int mid, input int hi);
		write_reg(REG_LOW,  {6'($urandom_range(0, 63)), SAMPLE_W'(lo)});
		write_reg(REG_MID,  {6'($urandom_range(0, 63)), SAMPLE_W'(mid)});
		write_reg(REG_HIGH, {6'($urandom_range(0, 63)), SAMPLE_W'(hi)});
	endtask

	initial begin
		result_t             typed_rec;
		logic [SAMPLE_W-1:0] smp;
		logic [TIMER_W-1:0]  tv;
		int                  base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PREAMBLE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		preamble_len = PREAMBLE_RST;
		sync_len = SYNC_RST;
		low_thr = LOW_RST;
		mid_thr = MID_RST;
		high_thr = HIGH_RST;
		level_q = 1'b0;
		transitions_seen = '0;
		period_avg = '0;
		byte_shift = '0;
		bits_packed = 0;
		byte_count = 0;
		track_done = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// band edges with the reset thresholds
		for (int i = 0; i < $size(DIRECTED); i++) begin
			typed_rec = '0;
			typed_rec.level = DIRECTED[i].lvl;
			typed_rec.phase = PH_PREAMBLE;
			send_sample(DIRECTED[i].smp, DIRECTED[i].tv, DIRECTED[i].typed, typed_rec);
		end

		// hold the preamble open and sweep threshold settings
		settle();
		write_reg(REG_PREAMBLE, 16'hfffe);
		write_reg(REG_SYNC, 16'hffff);
		write_reg(REG_UNUSED, 16'($urandom()));
		for (int round = 0; round < 8; round++) begin
			settle();
			case (round)
				1: load_thresholds(0, 0, 0);
				2: load_thresholds(1023, 1023, 1023);
				3: load_thresholds(0, 512, 1023);
				4: load_thresholds($urandom_range(0, 1023), $urandom_range(0, 1023),
				                   $urandom_range(0, 1023));
				5: begin
					// sync below the count: forced slicing while still in preamble
					write_reg(REG_SYNC, 16'd2);
					load_thresholds($urandom_range(0, 400), $urandom_range(401, 700),
					                $urandom_range(701, 1023));
				end
				6: begin
					write_reg(REG_SYNC, 16'hffff);
					load_thresholds($urandom_range(600, 1023), $urandom_range(300, 599),
					                $urandom_range(0, 299));
					hold_req = 1'b1;
				end
				7: load_thresholds($urandom_range(0, 400), $urandom_range(401, 700),
				                   $urandom_range(701, 1023));
				default: ;
			endcase
			repeat (70)
				send_sample(pick_sample(), TIMER_W'($urandom()));
		end

		// timer start, period averaging, then the sync reload
		settle();
		load_thresholds(255, 512, 768);
		write_reg(REG_PREAMBLE, transitions_seen);
		write_reg(REG_SYNC, transitions_seen + 16'($urandom_range(12, 40)));
		base = $urandom_range(40, 4000);
		while (transitions_seen <= sync_len) begin
			if ($urandom_range(0, 4) == 0)
				smp = pick_sample();
			else if (level_q)
				smp = SAMPLE_W'($urandom_range(mid_thr, high_thr - 1));
			else
				smp = SAMPLE_W'($urandom_range(low_thr + 1, mid_thr - 1));
			case ($urandom_range(0, 5))
				0:       tv = TIMER_W'($urandom());
				1:       tv = '0;
				default: tv = TIMER_W'(base + $urandom_range(0, 64) - 32);
			endcase
			send_sample(smp, tv);
		end

		// data bits in four chunks until the track fills
		for (int chunk = 0; chunk < 4; chunk++) begin
			settle();
			case (chunk)
				1: load_thresholds(0, 0, 0);
				2: load_thresholds(1023, 1023, 1023);
				3: load_thresholds($urandom_range(0, 1023), $urandom_range(0, 1023),
				                   $urandom_range(0, 1023));
				default: ;
			endcase
			repeat (32)
				send_sample(pick_sample(), TIMER_W'($urandom()));
		end

		// track full: everything after is ignored but still reported
		settle();
		load_thresholds($urandom_range(0, 1023), $urandom_range(0, 1023),
		                $urandom_range(0, 1023));
		repeat (380)
			send_sample(pick_sample(), TIMER_W'($urandom()));
		quiet = 1'b1;
		repeat (120)
			send_sample(pick_sample(), TIMER_W'($urandom()));
		settle();

		$display("Summary: %0d samples, %0d records checked; timer start at %0d transitions",
		         samples_sent, records_checked, start_count);
		$display("Summary: preamble, measuring, data and full phases, %0d bytes decoded",
		         byte_count);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* filelist.f */
rtl/f2f_pkg.sv
rtl/f2f_stripe_bit_decoder.sv
tb/sv/f2f_stripe_bit_decoder_test.sv
